FILE: design/rtli_pkg.sv
// Shared types, codes and constants for the radix tree lookup/insert block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtli_pkg;

   localparam int KEY_BITS       = 32;
   localparam int VALUE_BITS     = 32;
   localparam int DEF_MAX_RADIX  = 4;
   localparam int DEF_NODES      = 256;
   localparam int EPOCH_BITS     = 4;
   localparam int SHIFT_BITS     = $clog2(KEY_BITS);
   localparam int RADIX_EFF_BITS = 4;
   localparam int RADIX_FIELD    = 3;
   localparam int KEYLEN_FIELD   = 6;
   localparam int CSR_IDX_BITS   = 4;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [1:0] ACT_FIND   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] ST_FOUND   = 2'd0;
   localparam logic [1:0] ST_CREATED = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_RADIX  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_KEYLEN = 4'd1;

   localparam logic [1:0] SEL_ZERO  = 2'd0;
   localparam logic [1:0] SEL_READ  = 2'd1;
   localparam logic [1:0] SEL_VALUE = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] result_value;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [EPOCH_BITS-1:0] epoch;
      logic [VALUE_BITS-1:0] data;
   } slot_type;

   typedef struct packed {
      logic       load;
      logic       read;
      logic       descend;
      logic       alloc;
      logic       put_leaf;
      logic       respond;
      logic [1:0] rsp_status;
      logic [1:0] rsp_sel;
      logic       clear_bump;
      logic       sweep_start;
      logic       sweep_write;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic leaf;
      logic insert;
      logic pool_full;
      logic epoch_max;
      logic sweep_done;
      logic geom_busy;
      logic cfg_clear;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: design/rtli_datapath.sv
// Datapath: geometry registers, slot memory with epoch tags, walk registers.
// Depends on rtli_pkg; driven by rtli_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module rtli_datapath #(
   parameter int MAX_RADIX = rtli_pkg::DEF_MAX_RADIX,
   parameter int NODES     = rtli_pkg::DEF_NODES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rtli_pkg::req_type                    req_data,
   input  logic                                 csr_valid,
   input  logic [rtli_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rtli_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  rtli_pkg::dp_cmd_type                 dp_cmd,
   output rtli_pkg::dp_status_type              dp_status,
   output logic                                 rsp_valid,
   output rtli_pkg::rsp_type                    rsp_data
);
   import rtli_pkg::*;

   localparam int NODE_BITS     = $clog2(NODES);
   localparam int NODE_CNT_BITS = $clog2(NODES + 1);
   localparam int ADDR_BITS     = NODE_BITS + MAX_RADIX;
   localparam int DEPTH         = NODES * (2 ** MAX_RADIX);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

   slot_type mem [DEPTH];

   logic [RADIX_FIELD-1:0]    radix_ff;
   logic [KEYLEN_FIELD-1:0]   keylen_ff;
   logic [SHIFT_BITS-1:0]     top_shift_ff, top_shift_in;
   logic                      geom_busy_ff, geom_busy_in;
   logic [EPOCH_BITS-1:0]     epoch_ff, epoch_in;
   logic [ADDR_BITS-1:0]      sweep_addr_ff, sweep_addr_in;
   logic [NODE_CNT_BITS-1:0]  next_free_ff, next_free_in;
   logic                      insert_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [VALUE_BITS-1:0]     value_ff;
   logic [NODE_BITS-1:0]      node_ff, node_in;
   logic [SHIFT_BITS-1:0]     shift_ff, shift_in;
   logic [ADDR_BITS-1:0]      addr_ff;
   slot_type                  rd_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff, rsp_in;

   logic                      csr_hit;
   logic [RADIX_EFF_BITS-1:0] r_eff;
   logic [KEYLEN_FIELD-1:0]   kb_eff;
   logic [SHIFT_BITS:0]       geom_sum;
   logic [MAX_RADIX-1:0]      idx_mask;
   logic [KEY_BITS-1:0]       key_sh;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic                      mem_we;
   logic [ADDR_BITS-1:0]      mem_waddr;
   slot_type                  mem_wdata;

   assign csr_hit = csr_valid && (csr_index == CSR_IDX_RADIX || csr_index == CSR_IDX_KEYLEN);

   always_comb begin
      if (radix_ff == '0) begin
         r_eff = RADIX_EFF_BITS'(1);
      end else if ({1'b0, radix_ff} > RADIX_EFF_BITS'(MAX_RADIX)) begin
         r_eff = RADIX_EFF_BITS'(MAX_RADIX);
      end else begin
         r_eff = {1'b0, radix_ff};
      end
      if (keylen_ff == '0) begin
         kb_eff = KEYLEN_FIELD'(1);
      end else if (keylen_ff > KEYLEN_FIELD'(KEY_BITS)) begin
         kb_eff = KEYLEN_FIELD'(KEY_BITS);
      end else begin
         kb_eff = keylen_ff;
      end
   end

   // top shift = largest multiple of r below the key length, found by stepping
   always_comb begin
      geom_sum     = {1'b0, top_shift_ff} + (SHIFT_BITS + 1)'(r_eff);
      top_shift_in = top_shift_ff;
      geom_busy_in = geom_busy_ff;
      if (csr_hit) begin
         top_shift_in = '0;
         geom_busy_in = 1'b1;
      end else if (geom_busy_ff) begin
         if ((KEYLEN_FIELD)'(geom_sum) < kb_eff) begin
            top_shift_in = geom_sum[SHIFT_BITS-1:0];
         end else begin
            geom_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_RADIX; i++) begin
         idx_mask[i] = (i < int'(r_eff));
      end
   end

   assign key_sh  = key_ff >> shift_ff;
   assign rd_addr = {node_ff, key_sh[MAX_RADIX-1:0] & idx_mask};

   always_comb begin
      epoch_in      = epoch_ff;
      sweep_addr_in = sweep_addr_ff;
      next_free_in  = next_free_ff;
      node_in       = node_ff;
      shift_in      = shift_ff;
      if (dp_cmd.sweep_start) begin
         epoch_in      = '0;
         sweep_addr_in = '0;
         next_free_in  = NODE_CNT_BITS'(1);
      end else if (dp_cmd.clear_bump) begin
         epoch_in     = epoch_ff + 1'b1;
         next_free_in = NODE_CNT_BITS'(1);
      end
      if (dp_cmd.sweep_write) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end
      if (dp_cmd.load) begin
         node_in  = '0;
         shift_in = top_shift_ff;
      end else if (dp_cmd.descend) begin
         node_in  = rd_ff.data[NODE_BITS-1:0];
         shift_in = shift_ff - SHIFT_BITS'(r_eff);
      end else if (dp_cmd.alloc) begin
         node_in      = next_free_ff[NODE_BITS-1:0];
         shift_in     = shift_ff - SHIFT_BITS'(r_eff);
         next_free_in = next_free_ff + 1'b1;
      end
   end

   always_comb begin
      mem_we    = dp_cmd.sweep_write || dp_cmd.alloc || dp_cmd.put_leaf;
      mem_waddr = dp_cmd.sweep_write ? sweep_addr_ff : addr_ff;
      mem_wdata = '0;
      if (dp_cmd.alloc) begin
         mem_wdata = '{valid: 1'b1, epoch: epoch_ff, data: VALUE_BITS'(next_free_ff)};
      end else if (dp_cmd.put_leaf) begin
         mem_wdata = '{valid: 1'b1, epoch: epoch_ff, data: value_ff};
      end
   end

   always_comb begin
      rsp_in.status = dp_cmd.rsp_status;
      case (dp_cmd.rsp_sel)
         SEL_READ:  rsp_in.result_value = rd_ff.data;
         SEL_VALUE: rsp_in.result_value = value_ff;
         default:   rsp_in.result_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (dp_cmd.read) begin
         rd_ff   <= mem[rd_addr];
         addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_FIELD'(4);
         keylen_ff     <= KEYLEN_FIELD'(32);
         top_shift_ff  <= '0;
         geom_busy_ff  <= 1'b1;
         epoch_ff      <= '0;
         sweep_addr_ff <= '0;
         next_free_ff  <= NODE_CNT_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_IDX_RADIX) begin
            radix_ff <= csr_data[RADIX_FIELD-1:0];
         end
         if (csr_valid && csr_index == CSR_IDX_KEYLEN) begin
            keylen_ff <= csr_data[KEYLEN_FIELD-1:0];
         end
         top_shift_ff  <= top_shift_in;
         geom_busy_ff  <= geom_busy_in;
         epoch_ff      <= epoch_in;
         sweep_addr_ff <= sweep_addr_in;
         next_free_ff  <= next_free_in;
         rsp_valid_ff  <= dp_cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         key_ff    <= req_data.key;
         value_ff  <= req_data.value;
         insert_ff <= (req_data.action == ACT_INSERT);
      end
      node_ff  <= node_in;
      shift_ff <= shift_in;
      if (dp_cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      dp_status.hit        = rd_ff.valid && (rd_ff.epoch == epoch_ff);
      dp_status.leaf       = (shift_ff == '0);
      dp_status.insert     = insert_ff;
      dp_status.pool_full  = (next_free_ff == NODE_CNT_BITS'(NODES));
      dp_status.epoch_max  = &epoch_ff;
      dp_status.sweep_done = (sweep_addr_ff == LAST_ADDR);
      dp_status.geom_busy  = geom_busy_ff;
      dp_status.cfg_clear  = csr_hit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: design/rtli_ctrl.sv
// Controller: sweep, idle, read and evaluate states of the tree walk.
// Depends on rtli_pkg; commands rtli_datapath.
`timescale 1ns / 1ps
`default_nettype none

module rtli_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_action,
   input  rtli_pkg::dp_status_type dp_status,
   output rtli_pkg::dp_cmd_type    dp_cmd,
   output logic                    busy
);
   import rtli_pkg::*;

   localparam logic [1:0] S_SWEEP = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_EVAL  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE) || dp_status.geom_busy;
   assign accept = start && !busy;

   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      if (dp_status.cfg_clear) begin
         if (state_ff == S_SWEEP || dp_status.epoch_max) begin
            dp_cmd.sweep_start = 1'b1;
            state_in           = S_SWEEP;
         end else begin
            dp_cmd.clear_bump = 1'b1;
         end
      end else begin
         unique case (state_ff)
            S_SWEEP: begin
               dp_cmd.sweep_write = 1'b1;
               if (dp_status.sweep_done) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  if (req_action == ACT_CLEAR) begin
                     dp_cmd.respond    = 1'b1;
                     dp_cmd.rsp_status = ST_FOUND;
                     dp_cmd.rsp_sel    = SEL_ZERO;
                     if (dp_status.epoch_max) begin
                        dp_cmd.sweep_start = 1'b1;
                        state_in           = S_SWEEP;
                     end else begin
                        dp_cmd.clear_bump = 1'b1;
                     end
                  end else begin
                     dp_cmd.load = 1'b1;
                     state_in    = S_READ;
                  end
               end
            end
            S_READ: begin
               dp_cmd.read = 1'b1;
               state_in    = S_EVAL;
            end
            S_EVAL: begin
               state_in = S_IDLE;
               if (dp_status.leaf) begin
                  dp_cmd.respond = 1'b1;
                  if (dp_status.hit) begin
                     dp_cmd.rsp_status = ST_FOUND;
                     dp_cmd.rsp_sel    = SEL_READ;
                  end else if (dp_status.insert) begin
                     dp_cmd.put_leaf   = 1'b1;
                     dp_cmd.rsp_status = ST_CREATED;
                     dp_cmd.rsp_sel    = SEL_VALUE;
                  end else begin
                     dp_cmd.rsp_status = ST_ABSENT;
                     dp_cmd.rsp_sel    = SEL_ZERO;
                  end
               end else if (dp_status.hit) begin
                  dp_cmd.descend = 1'b1;
                  state_in       = S_READ;
               end else if (dp_status.insert && !dp_status.pool_full) begin
                  dp_cmd.alloc = 1'b1;
                  state_in     = S_READ;
               end else begin
                  dp_cmd.respond    = 1'b1;
                  dp_cmd.rsp_status = dp_status.insert ? ST_FULL : ST_ABSENT;
                  dp_cmd.rsp_sel    = SEL_ZERO;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/radix_tree_lookup_insert.sv
// Top level of the fixed-height radix tree lookup/insert block.
// Depends on rtli_pkg, rtli_ctrl and rtli_datapath.
//
// An item is taken when start is high and busy low. Find and find-or-insert
// walk one tree level per visit to the read state (one slot memory read) and
// the evaluate state (evaluate and possible write); the result strobe follows
// the last evaluate through the response register, and the next item can be
// taken in the strobe cycle. A clear is answered in the cycle after acceptance.
// A write to either register also clears the tree and counts as a clear. Every
// sixteenth clear, and the period after reset, runs a sweep over all
// NODES << MAX_RADIX slots (4096 by default) of the slot memory while busy is
// high. After a register write that does not start a sweep, busy stays high
// while the walk geometry is recomputed.
// The result strobe lasts one cycle and cannot be held off; csr_ready is
// always high.
`timescale 1ns / 1ps
`default_nettype none

module radix_tree_lookup_insert #(
   parameter int MAX_RADIX = rtli_pkg::DEF_MAX_RADIX,
   parameter int NODES     = rtli_pkg::DEF_NODES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rtli_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output rtli_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rtli_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rtli_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rtli_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   rtli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .busy       (busy)
   );

   rtli_datapath #(
      .MAX_RADIX (MAX_RADIX),
      .NODES     (NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/rtli_checker.sv
// Port-level checks for radix_tree_lookup_insert, attached by bind.
// Depends on rtli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtli_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input rtli_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input rtli_pkg::rsp_type                   rsp_data,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [rtli_pkg::CSR_IDX_BITS-1:0]   csr_index
);
   import rtli_pkg::*;

   a_clear_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == ACT_CLEAR |=>
         rsp_valid && rsp_data.status == ST_FOUND && rsp_data.result_value == '0)
      else $error("clear item not answered next cycle with zero");

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action != ACT_CLEAR |=> busy)
      else $error("walk item accepted but block not busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_ABSENT || rsp_data.status == ST_FULL) |->
         rsp_data.result_value == '0)
      else $error("absent or pool-full result carries a value");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result without an item in flight");

   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready &&
         (csr_index == CSR_IDX_RADIX || csr_index == CSR_IDX_KEYLEN) |=> busy)
      else $error("register write did not hold off items");

endmodule

bind radix_tree_lookup_insert rtli_checker u_rtli_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index)
);

`default_nettype wire

FILE: bench/radix_tree_lookup_insert_tb.sv
// Self-checking testbench for radix_tree_lookup_insert: a clocked driver and monitor,
// with a tree predictor that mirrors the slot store and the bump allocator.
// Depends on rtli_pkg and the radix_tree_lookup_insert RTL.
`timescale 1ns / 1ps

module radix_tree_lookup_insert_tb;
   import rtli_pkg::*;

   localparam int          SLOTS_PER_NODE = 1 << DEF_MAX_RADIX;
   localparam int          STORE_DEPTH    = DEF_NODES * SLOTS_PER_NODE;
   localparam logic [1:0]  ACT_SPARE      = 2'd3;   // unused code, behaves as find
   localparam int          PHASES         = 12;
   localparam int          PHASE_ITEMS    = 158;
   localparam int          DRAIN_CYCLES   = 70;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   radix_tree_lookup_insert i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // tree mirror
   bit                  slot_used [STORE_DEPTH];
   logic [31:0]         slot_word [STORE_DEPTH];
   int unsigned         bump_node;
   logic [2:0]          radix_reg;
   logic [5:0]          keylen_reg;

   req_type             item_feed [$];
   rsp_type             lookup_due [$];
   logic [31:0]         hot_keys [$];
   int                  pushed_count = 0;
   int                  accepted_count = 0;
   int                  fail_count = 0;
   logic                item_taken = 1'b0;
   int                  gap_left = 0;
   bit                  no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void wipe_tree();
      int unsigned i;
      for (i = 0; i < STORE_DEPTH; i++) begin
         slot_used[i] = 1'b0;
         slot_word[i] = '0;
      end
      bump_node = 1;
   endfunction

   function automatic rsp_type walk_tree(req_type item);
      rsp_type     res;
      int unsigned r, kb, height, lvl, node, idx, addr, k;
      res = '0;
      res.status = ST_FOUND;
      if (item.action == ACT_CLEAR) begin
         wipe_tree();
         return res;
      end
      r = radix_reg;
      if (r < 1) r = 1;
      if (r > DEF_MAX_RADIX) r = DEF_MAX_RADIX;
      kb = keylen_reg;
      if (kb < 1) kb = 1;
      if (kb > KEY_BITS) kb = KEY_BITS;
      height = (kb + r - 1) / r;
      node = 0;
      for (lvl = height - 1; lvl > 0; lvl--) begin
         idx = (item.key >> (lvl * r)) & ((1 << r) - 1);
         addr = node * SLOTS_PER_NODE + idx;
         if (slot_used[addr]) begin
            node = slot_word[addr] % DEF_NODES;
         end else if (item.action == ACT_INSERT) begin
            if (bump_node >= DEF_NODES) begin
               res.status = ST_FULL;
               return res;
            end
            for (k = 0; k < SLOTS_PER_NODE; k++) begin
               slot_used[bump_node * SLOTS_PER_NODE + k] = 1'b0;
               slot_word[bump_node * SLOTS_PER_NODE + k] = '0;
            end
            slot_used[addr] = 1'b1;
            slot_word[addr] = bump_node;
            node = bump_node;
            bump_node++;
         end else begin
            res.status = ST_ABSENT;
            return res;
         end
      end
      idx = item.key & ((1 << r) - 1);
      addr = node * SLOTS_PER_NODE + idx;
      if (slot_used[addr]) begin
         res.status = ST_FOUND;
         res.result_value = slot_word[addr];
      end else if (item.action == ACT_INSERT) begin
         slot_used[addr] = 1'b1;
         slot_word[addr] = item.value;
         res.status = ST_CREATED;
         res.result_value = item.value;
      end else begin
         res.status = ST_ABSENT;
      end
      return res;
   endfunction

   // driver
   always @(negedge clock) begin : feed
      int roll;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (item_feed.size() > 0) begin
            req_data <= item_feed.pop_front();
            start <= 1'b1;
            if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
            roll = $urandom_range(0, 99);
            if (no_idle || roll < 60) gap_left <= 0;
            else if (roll < 92) gap_left <= $urandom_range(1, 3);
            else gap_left <= $urandom_range(10, 40);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin : observe
      rsp_type want;
      rsp_type got;
      item_taken <= start && !busy && !reset;
      if (reset) begin
         radix_reg = 3'd4;
         keylen_reg = 6'd32;
         wipe_tree();
      end else begin
         if (rsp_valid) begin
            got = rsp_data;
            if (lookup_due.size() == 0) begin
               $error("unexpected result: status %0d result_value %h",
                      got.status, got.result_value);
               fail_count++;
            end else begin
               want = lookup_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.result_value !== want.result_value) begin
                  $error("result_value: expected %h, got %h",
                         want.result_value, got.result_value);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDX_RADIX: begin
                  radix_reg = csr_data[2:0];
                  wipe_tree();
               end
               CSR_IDX_KEYLEN: begin
                  keylen_reg = csr_data;
                  wipe_tree();
               end
               default: ;
            endcase
         end
         if (start && !busy) begin
            lookup_due.push_back(walk_tree(req_data));
            accepted_count++;
         end
      end
   end

   task automatic queue_item(input logic [1:0] act, input logic [31:0] key,
                             input logic [31:0] val);
      req_type it;
      it.action = act;
      it.key = key;
      it.value = val;
      item_feed.push_back(it);
      pushed_count++;
   endtask

   task automatic settle();
      while (accepted_count != pushed_count || lookup_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      while (busy) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_key();
      int unsigned roll;
      logic [31:0] base;
      roll = $urandom_range(0, 99);
      if (hot_keys.size() == 0 || roll < 15) return $urandom;
      base = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
      if (roll < 55) return base;
      return base ^ ($urandom & ((32'd1 << $urandom_range(1, 12)) - 1));
   endfunction

   task automatic queue_random_item();
      logic [1:0]  act;
      logic [31:0] key;
      logic [31:0] val;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      key = pick_key();
      val = $urandom;
      if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? '0 : '1;
      if (roll < 3) act = ACT_CLEAR;
      else if (roll < 6) act = ACT_SPARE;
      else if (roll < 50) act = ACT_INSERT;
      else act = ACT_FIND;
      if (act == ACT_INSERT) begin
         hot_keys.push_back(key);
         if (hot_keys.size() > 64) void'(hot_keys.pop_front());
      end
      queue_item(act, key, val);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] radix_plan [7];
      logic [CSR_DATA_BITS-1:0] keylen_plan [7];
      int ph, n;
      // radix 56 and 7 exercise the masked and saturated cases, keylen 0 and 63 the zero and saturated cases
      radix_plan  = '{6'd1, 6'd1, 6'd4, 6'd56, 6'd7, 6'd2, 6'd3};
      keylen_plan = '{6'd1, 6'd32, 6'd32, 6'd0, 6'd63, 6'd8, 6'd7};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // directed items at the reset geometry
      @(posedge clock);
      queue_item(ACT_FIND,   32'h0000_0000, 32'h1111_1111);
      queue_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
      queue_item(ACT_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
      queue_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0005);
      queue_item(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(ACT_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
      queue_item(ACT_SPARE,  32'hFFFF_FFFF, 32'h0000_0000);
      queue_item(ACT_SPARE,  32'h1234_5678, 32'h0000_0000);
      queue_item(ACT_FIND,   32'hFFFF_FFFE, 32'h0000_0000);
      queue_item(ACT_FIND,   32'h7FFF_FFFF, 32'h0000_0000);
      queue_item(ACT_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      queue_item(ACT_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
      queue_item(ACT_FIND,   32'hA5A5_A5A5, 32'h0000_0000);
      queue_item(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(ACT_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
      queue_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h8000_0001);

      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph < 7) begin
            write_reg(CSR_IDX_RADIX, radix_plan[ph]);
            write_reg(CSR_IDX_KEYLEN, keylen_plan[ph]);
         end else if (ph == 7) begin
            // spare index only, tree contents carry over
            write_reg(CSR_IDX_BITS'($urandom_range(2, 15)), CSR_DATA_BITS'($urandom));
         end else begin
            write_reg(CSR_IDX_RADIX, CSR_DATA_BITS'($urandom_range(0, 63)));
            write_reg(CSR_IDX_KEYLEN, CSR_DATA_BITS'($urandom_range(0, 63)));
         end
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_IDX_BITS'($urandom_range(2, 15)), CSR_DATA_BITS'($urandom));
         if (ph != 7) hot_keys.delete();
         @(posedge clock);
         for (n = 0; n < PHASE_ITEMS; n++) queue_random_item();
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
design/rtli_pkg.sv
design/rtli_datapath.sv
design/rtli_ctrl.sv
design/radix_tree_lookup_insert.sv
design/rtli_checker.sv
bench/radix_tree_lookup_insert_tb.sv
